// File: hdl/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and constants of the positional list engine: request and
// status codes, the operation broadcast along the storage chain, and the
// stream beat layout.
// ----------------------------------------------------------------------------
package ple_pkg;

    localparam int VALUE_W   = 31;
    localparam int POS_W     = 6;
    localparam int REQ_W     = 2;
    localparam int STATUS_W  = 2;

    // Slave beat: position, element_value.
    localparam int S_TDATA_W = ((POS_W + VALUE_W + 7) / 8) * 8;
    // Master beat: status, removed_value, removed_valid, item_value, item_position.
    localparam int M_FIELD_W = STATUS_W + VALUE_W + 1 + VALUE_W + POS_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    typedef logic [VALUE_W-1:0] t_value;

    typedef enum logic [REQ_W-1:0] {
        REQ_APPEND  = 2'd0,
        REQ_INSERT  = 2'd1,
        REQ_DELETE  = 2'd2,
        REQ_REVERSE = 2'd3
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_ROTATE
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        t_value   din;
        t_value   head;
    } t_cell_ctrl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_REVERSE,
        S_EMIT
    } t_state;

endpackage

// File: hdl/ple_cell.sv
// ----------------------------------------------------------------------------
// ple_cell
// One storage slot of the list chain. Each cycle it keeps its value, takes
// its left or right neighbor's value, or loads the broadcast value, as the
// chain operation and its own position relative to the selected slot say.
// ----------------------------------------------------------------------------
module ple_cell #(
    parameter int IDX_W    = 5,
    parameter int CELL_IDX = 0
) (
    input  logic                  i_clk,
    input  ple_pkg::t_cell_ctrl   i_ctrl,
    input  logic [IDX_W-1:0]      i_sel,
    input  ple_pkg::t_value       i_left,
    input  ple_pkg::t_value       i_right,
    output ple_pkg::t_value       o_value,
    output ple_pkg::t_value       o_pick
);
    import ple_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    t_value r_value;
    t_value n_value;

    always_comb begin
        n_value = r_value;
        unique case (i_ctrl.op)
            CELL_HOLD: begin
                n_value = r_value;
            end
            CELL_INSERT: begin
                // Slots above the insertion point move one place up.
                if (MY_IDX > i_sel) begin
                    n_value = i_left;
                end else if (MY_IDX == i_sel) begin
                    n_value = i_ctrl.din;
                end
            end
            CELL_DELETE: begin
                if (MY_IDX >= i_sel) begin
                    n_value = i_right;
                end
            end
            CELL_ROTATE: begin
                // Left rotation of slots 0 through i_sel; the front wraps to i_sel.
                if (MY_IDX < i_sel) begin
                    n_value = i_right;
                end else if (MY_IDX == i_sel) begin
                    n_value = i_ctrl.head;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_pick  = (MY_IDX == i_sel) ? r_value : '0;

endmodule

// File: hdl/positional_list_engine_unit.sv
// ----------------------------------------------------------------------------
// positional_list_engine_unit
// Ordered list of up to CAPACITY values with append, insert, delete and
// reverse requests; the whole list is streamed out after every request.
// ----------------------------------------------------------------------------
// A request beat is taken in the idle state, and the same cycle applies append,
// insert or delete to the storage chain. For a list of two or more, reverse
// then does one shrinking left rotation of the chain per cycle. The list is
// streamed out one beat per cycle while the output is not stalled, by rotating
// the chain through its front slot; an empty list gives a single beat. A new
// request is taken as soon as the last beat of the previous one sits in the
// output register.
module positional_list_engine_unit #(
    parameter int CAPACITY = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // [5:0] position, [36:6] element_value, upper bits zero
    input  logic [ple_pkg::S_TDATA_W-1:0]  i_s_tdata,
    // [1:0] req_type
    input  logic [ple_pkg::REQ_W-1:0]      i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // [1:0] status, [32:2] removed_value, [33] removed_valid,
    // [64:34] item_value, [70:65] item_position, upper bits zero
    output logic [ple_pkg::M_TDATA_W-1:0]  o_m_tdata,
    // [0] list_empty
    output logic                           o_m_tuser,
    output logic                           o_m_tlast
);
    import ple_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int LEN_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (LEN_W > POS_W) ? LEN_W : POS_W;
    localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(CAPACITY);
    localparam int PAD_W = M_TDATA_W - M_FIELD_W;

    t_state             r_state, n_state;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [LEN_W-1:0]   r_cnt, n_cnt;
    logic [IDX_W-1:0]   r_win, n_win;
    t_status            r_status, n_status;
    t_value             r_removed, n_removed;
    logic               r_removed_ok, n_removed_ok;

    logic               r_out_valid, n_out_valid;
    t_status            r_out_status;
    t_value             r_out_removed;
    logic               r_out_removed_ok;
    logic               r_out_empty;
    t_value             r_out_item;
    logic [POS_W-1:0]   r_out_pos;
    logic               r_out_last;

    // Request decode.
    logic               w_accept;
    t_req               w_req;
    logic [POS_W-1:0]   w_pos;
    t_value             w_din;
    logic [CMP_W-1:0]   w_pos_c;
    logic [CMP_W-1:0]   w_len_c;
    logic               w_full;
    t_cell_op           w_dec_op;
    logic [IDX_W-1:0]   w_dec_sel;
    t_status            w_dec_status;
    logic [LEN_W-1:0]   w_dec_len;
    logic               w_dec_del;

    // Chain control and emission.
    t_cell_ctrl         w_ctrl;
    logic [IDX_W-1:0]   w_sel;
    logic               w_out_free;
    logic               w_load;
    logic               w_emit_last;
    t_value             w_pick_bus;
    t_value             w_cell [CAPACITY];
    t_value             w_pick [CAPACITY];

    assign w_accept = i_s_tvalid && o_s_tready;
    assign w_req    = t_req'(i_s_tuser);
    assign w_pos    = i_s_tdata[POS_W-1:0];
    assign w_din    = i_s_tdata[POS_W+VALUE_W-1:POS_W];
    assign w_pos_c  = CMP_W'(w_pos);
    assign w_len_c  = CMP_W'(r_len);
    assign w_full   = (r_len == LEN_FULL);

    always_comb begin
        w_dec_op     = CELL_HOLD;
        w_dec_sel    = '0;
        w_dec_status = ST_OK;
        w_dec_len    = r_len;
        w_dec_del    = 1'b0;
        unique case (w_req)
            REQ_APPEND: begin
                if (w_full) begin
                    w_dec_status = ST_FULL;
                end else begin
                    w_dec_op  = CELL_INSERT;
                    w_dec_sel = IDX_W'(r_len);
                    w_dec_len = r_len + LEN_W'(1);
                end
            end
            REQ_INSERT: begin
                // The range check takes precedence over the full check.
                if (w_pos_c > w_len_c) begin
                    w_dec_status = ST_RANGE;
                end else if (w_full) begin
                    w_dec_status = ST_FULL;
                end else begin
                    w_dec_op  = CELL_INSERT;
                    w_dec_sel = IDX_W'(w_pos);
                    w_dec_len = r_len + LEN_W'(1);
                end
            end
            REQ_DELETE: begin
                if ((w_pos == '0) || (w_pos_c > w_len_c)) begin
                    w_dec_status = ST_RANGE;
                end else begin
                    w_dec_op  = CELL_DELETE;
                    w_dec_sel = IDX_W'(w_pos - POS_W'(1));
                    w_dec_len = r_len - LEN_W'(1);
                    w_dec_del = 1'b1;
                end
            end
            REQ_REVERSE: begin
                w_dec_op = CELL_HOLD;
            end
            default: begin
                w_dec_op = CELL_HOLD;
            end
        endcase
    end

    assign w_out_free  = !r_out_valid || i_m_tready;
    assign w_emit_last = (r_len == '0) || ((r_cnt + LEN_W'(1)) == r_len);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if ((w_req == REQ_REVERSE) && (r_len >= LEN_W'(2))) begin
                        n_state = S_REVERSE;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_REVERSE: begin
                if (r_win == IDX_W'(1)) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free && w_emit_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State outputs: handshake and chain operation.
    always_comb begin
        o_s_tready  = 1'b0;
        w_load      = 1'b0;
        w_ctrl.op   = CELL_HOLD;
        w_ctrl.din  = w_din;
        w_ctrl.head = w_cell[0];
        w_sel       = '0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                w_ctrl.op  = i_s_tvalid ? w_dec_op : CELL_HOLD;
                w_sel      = w_dec_sel;
            end
            S_REVERSE: begin
                w_ctrl.op = CELL_ROTATE;
                w_sel     = r_win;
            end
            S_EMIT: begin
                // Each beat rotates the whole list by one; after L beats it is back.
                w_load    = w_out_free;
                w_ctrl.op = (w_out_free && (r_len != '0)) ? CELL_ROTATE : CELL_HOLD;
                w_sel     = IDX_W'(r_len - LEN_W'(1));
            end
            default: begin
                w_ctrl.op = CELL_HOLD;
            end
        endcase
    end

    for (genvar k = 0; k < CAPACITY; k++) begin : g_chain
        t_value w_left;
        t_value w_right;
        if (k == 0) begin : g_first
            assign w_left = w_din;
        end else begin : g_mid_l
            assign w_left = w_cell[k-1];
        end
        if (k == CAPACITY - 1) begin : g_last
            assign w_right = w_cell[k];
        end else begin : g_mid_r
            assign w_right = w_cell[k+1];
        end
        ple_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (k)
        ) u_slot (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_sel   (w_sel),
            .i_left  (w_left),
            .i_right (w_right),
            .o_value (w_cell[k]),
            .o_pick  (w_pick[k])
        );
    end

    // The deleted value is read from the selected slot over a one-hot bus.
    always_comb begin
        w_pick_bus = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_pick_bus = w_pick_bus | w_pick[k];
        end
    end

    // Next values of the request registers.
    always_comb begin
        n_len        = r_len;
        n_cnt        = r_cnt;
        n_win        = r_win;
        n_status     = r_status;
        n_removed    = r_removed;
        n_removed_ok = r_removed_ok;
        n_out_valid  = r_out_valid;
        if (w_accept) begin
            n_len        = w_dec_len;
            n_cnt        = '0;
            n_win        = IDX_W'(r_len - LEN_W'(1));
            n_status     = w_dec_status;
            n_removed    = w_dec_del ? w_pick_bus : '0;
            n_removed_ok = w_dec_del;
        end
        if (r_state == S_REVERSE) begin
            n_win = r_win - IDX_W'(1);
        end
        if (w_load) begin
            n_cnt       = r_cnt + LEN_W'(1);
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_cnt       <= '0;
            r_win       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_cnt       <= n_cnt;
            r_win       <= n_win;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status     <= n_status;
        r_removed    <= n_removed;
        r_removed_ok <= n_removed_ok;
        if (w_load) begin
            r_out_status     <= r_status;
            r_out_removed    <= r_removed;
            r_out_removed_ok <= r_removed_ok;
            r_out_empty      <= (r_len == '0);
            r_out_item       <= (r_len == '0) ? '0 : w_cell[0];
            r_out_pos        <= (r_len == '0) ? '0 : POS_W'(r_cnt + LEN_W'(1));
            r_out_last       <= w_emit_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{PAD_W{1'b0}}, r_out_pos, r_out_item, r_out_removed_ok,
                         r_out_removed, r_out_status};
    assign o_m_tuser  = r_out_empty;
    assign o_m_tlast  = r_out_last;

    ap_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_FULL)
        else $error("list length exceeds capacity");

    ap_len_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> ((r_len == $past(r_len)) || (r_len == $past(r_len) + LEN_W'(1)) ||
                      ((r_len + LEN_W'(1)) == $past(r_len))))
        else $error("one request changed the length by more than one");

    ap_len_busy_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |=> (r_len == $past(r_len)))
        else $error("length changed while a request was being emitted");

    ap_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_emit_last) |=> ((r_state == S_IDLE) && o_m_tvalid && o_m_tlast))
        else $error("final beat did not return the engine to idle");

    ap_removed_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_out_removed_ok) |-> (r_out_status == ST_OK))
        else $error("removed value flagged on a failed request");

endmodule

// File: dv/ple_checker.sv
// ----------------------------------------------------------------------------
// ple_checker
// Watches both stream channels of the positional list engine. Every accepted
// request is applied to a shadow copy of the list, and the beats that it
// should produce are queued. Every output beat is compared field by field
// with the oldest queued beat.
// ----------------------------------------------------------------------------
module ple_checker #(
    parameter int CAPACITY = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    // [5:0] position, [36:6] element_value, upper bits zero
    input  logic [ple_pkg::S_TDATA_W-1:0] i_s_tdata,
    // [1:0] req_type
    input  logic [ple_pkg::REQ_W-1:0]     i_s_tuser,
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    // [1:0] status, [32:2] removed_value, [33] removed_valid,
    // [64:34] item_value, [70:65] item_position, upper bits zero
    input  logic [ple_pkg::M_TDATA_W-1:0] i_m_tdata,
    // [0] list_empty
    input  logic                          i_m_tuser,
    input  logic                          i_m_tlast,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_list_len
);
    timeunit 1ns;
    timeprecision 1ps;

    import ple_pkg::*;

    typedef struct {
        t_status          status;
        t_value           removed;
        logic             removed_valid;
        logic             empty;
        t_value           value;
        logic [POS_W-1:0] position;
        logic             last;
    } t_list_beat;

    t_value     shadow_list[$];
    t_list_beat pending_beats[$];

    function automatic string beat_text(t_list_beat b);
        return $sformatf("status=%0d removed=%h valid=%b empty=%b value=%h pos=%0d last=%b",
                         b.status, b.removed, b.removed_valid, b.empty, b.value,
                         b.position, b.last);
    endfunction

    function automatic void log_failure(string text);
        o_fail_count++;
        if (o_fail_count <= 10) begin
            $display("%0t ns: %s", $realtime, text);
        end
    endfunction

    // Applies one request to the shadow list and queues the beats it emits.
    function automatic void apply_request(t_req kind, logic [POS_W-1:0] pos, t_value val);
        t_list_beat b;
        t_value     swap;
        int         lo;
        int         hi;
        b.status        = ST_OK;
        b.removed       = '0;
        b.removed_valid = 1'b0;
        case (kind)
            REQ_APPEND: begin
                if (shadow_list.size() >= CAPACITY) begin
                    b.status = ST_FULL;
                end else begin
                    shadow_list.push_back(val);
                end
            end
            REQ_INSERT: begin
                // The range check takes precedence over the full check.
                if (pos > shadow_list.size()) begin
                    b.status = ST_RANGE;
                end else if (shadow_list.size() >= CAPACITY) begin
                    b.status = ST_FULL;
                end else begin
                    shadow_list.insert(pos, val);
                end
            end
            REQ_DELETE: begin
                if (pos == 0 || pos > shadow_list.size()) begin
                    b.status = ST_RANGE;
                end else begin
                    b.removed       = shadow_list[pos - 1];
                    b.removed_valid = 1'b1;
                    shadow_list.delete(pos - 1);
                end
            end
            default: begin
                lo = 0;
                hi = shadow_list.size() - 1;
                while (lo < hi) begin
                    swap            = shadow_list[lo];
                    shadow_list[lo] = shadow_list[hi];
                    shadow_list[hi] = swap;
                    lo++;
                    hi--;
                end
            end
        endcase

        if (shadow_list.size() == 0) begin
            b.empty    = 1'b1;
            b.value    = '0;
            b.position = '0;
            b.last     = 1'b1;
            pending_beats.push_back(b);
        end else begin
            b.empty = 1'b0;
            for (int k = 0; k < shadow_list.size(); k++) begin
                b.value    = shadow_list[k];
                b.position = POS_W'(k + 1);
                b.last     = (k + 1 == shadow_list.size());
                pending_beats.push_back(b);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        t_list_beat got;
        t_list_beat want;
        if (!i_rst_n) begin
            shadow_list.delete();
            pending_beats.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.status        = t_status'(i_m_tdata[1:0]);
                got.removed       = i_m_tdata[32:2];
                got.removed_valid = i_m_tdata[33];
                got.value         = i_m_tdata[64:34];
                got.position      = i_m_tdata[70:65];
                got.empty         = i_m_tuser;
                got.last          = i_m_tlast;
                if (pending_beats.size() == 0) begin
                    log_failure({"unexpected beat: ", beat_text(got)});
                end else begin
                    want = pending_beats.pop_front();
                    if (got.status != want.status || got.removed != want.removed ||
                        got.removed_valid != want.removed_valid ||
                        got.empty != want.empty || got.value != want.value ||
                        got.position != want.position || got.last != want.last) begin
                        log_failure({"beat mismatch\n  expected: ", beat_text(want),
                                     "\n  actual:   ", beat_text(got)});
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                apply_request(t_req'(i_s_tuser), i_s_tdata[POS_W-1:0],
                              i_s_tdata[POS_W +: VALUE_W]);
            end
        end
        o_pending  <= pending_beats.size();
        o_list_len <= shadow_list.size();
    end

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives list requests into the positional list engine: a short directed
// sequence of corner cases, then random phases that grow, shrink and churn
// the list. Requests come in bursts with random gaps while the output side
// stalls on its own pattern; a separate checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ple_pkg::*;

    localparam int LIST_CAP    = 32;
    localparam int ITEM_TARGET = 420;
    localparam int QUIET_LIMIT = 3000;
    localparam int DRAIN_WAIT  = 80;

    typedef enum int {
        MIX_GROW,
        MIX_SHRINK,
        MIX_BALANCED,
        MIX_NOISE
    } t_mix;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [REQ_W-1:0]     s_tuser  = '0;
    logic                 m_tready = 1'b0;
    logic                 s_tready;
    logic                 m_tvalid;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;

    int fail_count;
    int pending;
    int list_len;
    int burst_left = 0;
    int stall_cycle = 0;
    int quiet_cycles = 0;

    always #5 clk = ~clk;

    positional_list_engine_unit #(
        .CAPACITY(LIST_CAP)
    ) dut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(s_tready),
        .i_s_tdata (s_tdata),
        .i_s_tuser (s_tuser),
        .o_m_tvalid(m_tvalid),
        .i_m_tready(m_tready),
        .o_m_tdata (m_tdata),
        .o_m_tuser (m_tuser),
        .o_m_tlast (m_tlast)
    );

    ple_checker #(
        .CAPACITY(LIST_CAP)
    ) checker_i (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tuser   (m_tuser),
        .i_m_tlast   (m_tlast),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_list_len  (list_len)
    );

    // The output side cycles through free flow, coin flips, a fixed duty
    // pattern and heavy stalling, in phases of equal length.
    always @(posedge clk) begin
        stall_cycle <= stall_cycle + 1;
        case ((stall_cycle / 128) % 4)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= (stall_cycle % 4) != 3;
            default: m_tready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("FAIL");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Sends one request beat, opening a new burst after a random gap when the
    // current burst is used up.
    task automatic issue(t_req kind, logic [POS_W-1:0] pos, t_value val);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= S_TDATA_W'({val, pos});
        do @(posedge clk); while (!s_tready);
    endtask

    // Holds the request side idle until every expected beat has been seen.
    task automatic drain_all();
        s_tvalid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
        burst_left = 0;
    endtask

    // Length is a hint from the checker; it may trail the requests in flight.
    task automatic random_request(t_mix mix);
        int               roll;
        t_req             kind;
        logic [POS_W-1:0] pos;
        t_value           val;
        roll = $urandom_range(0, 99);
        val  = t_value'($urandom);
        case (mix)
            MIX_GROW: begin
                kind = roll < 8 ? REQ_REVERSE : roll < 15 ? REQ_DELETE :
                       roll < 60 ? REQ_APPEND : REQ_INSERT;
            end
            MIX_SHRINK: begin
                kind = roll < 10 ? REQ_REVERSE : roll < 25 ? REQ_APPEND :
                       roll < 40 ? REQ_INSERT : REQ_DELETE;
            end
            default: kind = t_req'($urandom_range(0, 3));
        endcase
        if (mix == MIX_NOISE || $urandom_range(0, 9) == 0) begin
            pos = POS_W'($urandom_range(0, 63));
        end else if (kind == REQ_DELETE) begin
            pos = (list_len == 0) ? '0 : POS_W'($urandom_range(1, list_len));
        end else begin
            pos = POS_W'($urandom_range(0, list_len));
        end
        issue(kind, pos, val);
    endtask

    initial begin
        int   sent;
        int   phase_len;
        t_mix mix;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Out-of-range and no-op requests on the empty list.
        issue(REQ_DELETE, 6'd0, t_value'($urandom));
        issue(REQ_DELETE, 6'd1, t_value'($urandom));
        issue(REQ_REVERSE, 6'd0, t_value'($urandom));
        issue(REQ_INSERT, 6'd1, t_value'($urandom));
        // Insert at the front of an empty list, then reverse one element.
        issue(REQ_INSERT, 6'd0, '0);
        issue(REQ_REVERSE, 6'd0, '0);
        issue(REQ_APPEND, 6'd0, '1);
        issue(REQ_INSERT, 6'd63, t_value'($urandom));
        issue(REQ_REVERSE, 6'd63, '1);
        // Insert at the end and in the middle.
        issue(REQ_INSERT, 6'd2, 31'h2AAA_AAAA);
        issue(REQ_INSERT, 6'd1, 31'h5555_5555);
        issue(REQ_DELETE, 6'd63, '0);
        issue(REQ_DELETE, 6'd0, '0);
        // Delete the last element, then the first.
        issue(REQ_DELETE, 6'd4, '0);
        issue(REQ_DELETE, 6'd1, '0);
        issue(REQ_REVERSE, 6'd0, '0);
        issue(REQ_APPEND, 6'd21, 31'd1);
        issue(REQ_REVERSE, 6'd0, '0);
        issue(REQ_DELETE, 6'd2, '0);
        issue(REQ_DELETE, 6'd1, '0);
        // The next delete empties the list while reporting a removed value; the one after it is out of range.
        issue(REQ_DELETE, 6'd1, '0);
        issue(REQ_DELETE, 6'd1, '0);
        drain_all();

        // The first phase leans toward growth so that the full list is reached early.
        sent = 0;
        mix  = MIX_GROW;
        phase_len = 60;
        while (sent < ITEM_TARGET) begin
            for (int k = 0; k < phase_len && sent < ITEM_TARGET; k++) begin
                random_request(mix);
                sent++;
            end
            if ($urandom_range(0, 3) == 0) begin
                drain_all();
            end
            mix       = t_mix'($urandom_range(0, 3));
            phase_len = $urandom_range(20, 60);
        end

        s_tvalid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: positional_list_engine_unit.f
hdl/ple_pkg.sv
hdl/ple_cell.sv
hdl/positional_list_engine_unit.sv
dv/ple_checker.sv
dv/testbench.sv
